// File: rtl/dhcp_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_pkg
// Shared types and codes of the lease table server.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dhcp_pkg;

   localparam logic [1:0] MSG_DISCOVER = 2'd0;
   localparam logic [1:0] MSG_REQUEST  = 2'd1;
   localparam logic [1:0] MSG_RELEASE  = 2'd2;
   localparam logic [1:0] MSG_OTHER    = 2'd3;

   localparam logic [1:0] REPLY_NONE  = 2'd0;
   localparam logic [1:0] REPLY_OFFER = 2'd1;
   localparam logic [1:0] REPLY_ACK   = 2'd2;
   localparam logic [1:0] REPLY_NAK   = 2'd3;

   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_OFFER    = 2'd1;
   localparam logic [1:0] ST_ASSIGNED = 2'd2;

   localparam logic [1:0] CSR_FIRST_IP  = 2'd0;
   localparam logic [1:0] CSR_END_IP    = 2'd1;
   localparam logic [1:0] CSR_OFFER_SEC = 2'd2;
   localparam logic [1:0] CSR_ACK_SEC   = 2'd3;

   // classified request handed from front to back
   typedef struct packed {
      logic        discover;   // else request with address
      logic [47:0] mac;
      logic [31:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ip;
      logic [15:0] lease;
   } reply_type;

endpackage
`default_nettype wire

// File: rtl/dhcp_front.sv
// ----------------------------------------------------------------------------
// dhcp_front
// Accepts requests, marks those needing no table work, queues them all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dhcp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic              xid_nonzero,
   input  wire logic              mac_given,
   input  wire logic [47:0]       client_mac,
   input  wire logic              client_ip_given,
   input  wire logic [31:0]       client_ip,
   input  wire logic              option_ip_given,
   input  wire logic [31:0]       option_ip,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output logic                   q_work,
   output dhcp_pkg::cmd_type      q_cmd
);
   // two-entry queue
   logic [1:0]          cnt_ff, cnt_in;
   logic                rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]          work_ff;
   dhcp_pkg::cmd_type   cmd_ff [2];
   logic                push, pop, work;
   dhcp_pkg::cmd_type   cmd;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_work    = work_ff[rd_ff];
   assign q_cmd     = cmd_ff[rd_ff];

   always_comb begin
      cmd.discover = (req_type == dhcp_pkg::MSG_DISCOVER);
      cmd.mac      = client_mac;
      cmd.addr     = client_ip_given ? client_ip : option_ip;
      work = xid_nonzero && mac_given &&
             (cmd.discover || (req_type == dhcp_pkg::MSG_REQUEST &&
                               (client_ip_given || option_ip_given)));
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         work_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         if (push) work_ff[wr_ff] <= work;
      end
   end

   always_ff @(posedge clock) begin
      if (push) cmd_ff[wr_ff] <= cmd;
   end
endmodule
`default_nettype wire

// File: rtl/dhcp_back.sv
// ----------------------------------------------------------------------------
// dhcp_back
// Lease table and its sequencer: walks records one a cycle for each lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dhcp_back #(
   parameter int RECORD_COUNT = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire logic              q_work,
   input  wire dhcp_pkg::cmd_type q_cmd,
   input  wire logic [31:0]       first_ip,
   input  wire logic [31:0]       end_ip,
   input  wire logic [15:0]       offer_sec,
   input  wire logic [15:0]       ack_sec,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dhcp_pkg::reply_type    rsp_data
);
   localparam int IW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
   localparam int CW = $clog2(RECORD_COUNT + 1);   // counts 0..RECORD_COUNT
   localparam logic [CW-1:0] LAST = CW'(RECORD_COUNT - 1);
   localparam logic [CW-1:0] NCAND = CW'(RECORD_COUNT);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOOK = 5'b00010,   // MAC walk (discover) or MAC+IP walk (request)
      S_SCAN = 5'b00100,   // candidate against every record
      S_DONE = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          status_ff [RECORD_COUNT];
   logic [47:0]         mac_ff    [RECORD_COUNT];
   logic [31:0]         ip_ff     [RECORD_COUNT];
   dhcp_pkg::cmd_type   cmd_ff;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       ncand_ff, ncand_in;
   logic [31:0]         cand_ff, cand_in;
   logic                mhit_ff, mhit_in, fhit_ff, fhit_in, chit_ff, chit_in;
   logic [IW-1:0]       mrec_ff, mrec_in, frec_ff, frec_in;
   dhcp_pkg::reply_type out_ff, out_in;
   logic                wr_en;
   logic [IW-1:0]       wr_idx;
   logic [1:0]          wr_status;
   logic                wr_full;
   logic [IW-1:0]       cur;
   logic                mac_eq, ip_eq, cand_eq, last;

   assign cur     = idx_ff[IW-1:0];
   assign mac_eq  = (mac_ff[cur] == cmd_ff.mac);
   assign ip_eq   = (ip_ff[cur] == cmd_ff.addr);
   assign cand_eq = (ip_ff[cur] == cand_ff);
   assign last    = (idx_ff == LAST);
   assign q_ready   = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ncand_in = ncand_ff;
      cand_in  = cand_ff;
      mhit_in  = mhit_ff;
      fhit_in  = fhit_ff;
      chit_in  = chit_ff;
      mrec_in  = mrec_ff;
      frec_in  = frec_ff;
      out_in   = out_ff;
      wr_en    = 1'b0;
      wr_idx   = mrec_ff;
      wr_status = dhcp_pkg::ST_OFFER;
      wr_full  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            out_in = '{dhcp_pkg::REPLY_NONE, 32'd0, 16'd0};
            idx_in = '0;
            mhit_in = 1'b0;
            fhit_in = 1'b0;
            if (q_valid) state_in = q_work ? S_LOOK : S_OUT;
         end
         S_LOOK: begin
            if (cmd_ff.discover) begin
               if (!mhit_ff && mac_eq) begin
                  mhit_in = 1'b1;
                  mrec_in = cur;
               end
               if (!fhit_ff && status_ff[cur] == dhcp_pkg::ST_FREE) begin
                  fhit_in = 1'b1;
                  frec_in = cur;
               end
            end else if (!mhit_ff && mac_eq && ip_eq) begin
               mhit_in = 1'b1;
               mrec_in = cur;
            end
            idx_in = idx_ff + 1'b1;
            if (last) state_in = S_DONE;
         end
         S_SCAN: begin
            if (cand_eq) chit_in = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (last) begin
               idx_in = '0;
               if (!chit_in) begin
                  // candidate free: claim record
                  wr_en   = 1'b1;
                  wr_full = 1'b1;
                  wr_idx  = mrec_ff;
                  out_in  = '{dhcp_pkg::REPLY_OFFER, cand_ff, offer_sec};
                  state_in = S_OUT;
               end else begin
                  chit_in  = 1'b0;
                  cand_in  = cand_ff + 32'd1;
                  ncand_in = ncand_ff + 1'b1;
                  if (ncand_ff == NCAND || cand_in == end_ip) state_in = S_OUT;
               end
            end
         end
         S_DONE: begin
            if (cmd_ff.discover) begin
               if (mhit_ff && ip_ff[mrec_ff] != 32'd0) begin
                  wr_en  = 1'b1;
                  out_in = '{dhcp_pkg::REPLY_OFFER, ip_ff[mrec_ff], offer_sec};
                  state_in = S_OUT;
               end else if (!mhit_ff && !fhit_ff) begin
                  state_in = S_OUT;
               end else begin
                  if (!mhit_ff) mrec_in = frec_ff;
                  cand_in  = first_ip;
                  ncand_in = '0;
                  chit_in  = 1'b0;
                  idx_in   = '0;
                  state_in = (first_ip == end_ip) ? S_OUT : S_SCAN;
               end
            end else begin
               if (!mhit_ff || !(status_ff[mrec_ff] == dhcp_pkg::ST_OFFER ||
                                 status_ff[mrec_ff] == dhcp_pkg::ST_ASSIGNED)) begin
                  out_in = '{dhcp_pkg::REPLY_NAK, 32'd0, 16'd0};
               end else begin
                  wr_en     = 1'b1;
                  wr_status = dhcp_pkg::ST_ASSIGNED;
                  out_in = '{dhcp_pkg::REPLY_ACK, ip_ff[mrec_ff], ack_sec};
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < RECORD_COUNT; i++) begin
            status_ff[i] <= dhcp_pkg::ST_FREE;
            mac_ff[i]    <= '0;
            ip_ff[i]     <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            status_ff[wr_idx] <= wr_status;
            if (wr_full) begin
               mac_ff[wr_idx] <= cmd_ff.mac;
               ip_ff[wr_idx]  <= cand_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) cmd_ff <= q_cmd;
      idx_ff   <= idx_in;
      ncand_ff <= ncand_in;
      cand_ff  <= cand_in;
      mhit_ff  <= mhit_in;
      fhit_ff  <= fhit_in;
      chit_ff  <= chit_in;
      mrec_ff  <= mrec_in;
      frec_ff  <= frec_in;
      out_ff   <= out_in;
   end
endmodule
`default_nettype wire

// File: rtl/dhcp_lease_table_server_top.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_server_top
// DHCP server lease table: classifies client messages and answers offers,
// acks and naks from a table of lease records.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (valid/ready), one parsed client message each.
//   Every request yields exactly one response on rsp_* (valid/ready);
//   rsp_reply_kind of zero means no reply is to be sent.
//   Range and lease registers are written through csr_*; the user must
//   write them only while idle, and the block does not enforce this.
//   A request needing no table work goes straight to the response; the
//   rest walk the table in the lookup, one record a cycle. A discover
//   that scans the range walks the table again with a single compare
//   for each candidate tried, at most RECORD_COUNT + 1 candidates.
//   Throughput: one request in the sequencer at a time; the next starts the
//   cycle after the previous response is taken.
//   A two-entry queue between the front and the table sequencer lets
//   requests be taken while a response waits; when rsp_ready is low the
//   response holds and the queue fills, then req_ready falls.
//   Reset clears all records to free with zero MAC and address, and loads
//   the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dhcp_lease_table_server_top #(
   parameter int RECORD_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_xid_nonzero,
   input  wire logic        req_mac_given,
   input  wire logic [47:0] req_client_mac,
   input  wire logic        req_client_ip_given,
   input  wire logic [31:0] req_client_ip,
   input  wire logic        req_option_ip_given,
   input  wire logic [31:0] req_option_ip,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_reply_kind,
   output logic [31:0]      rsp_your_ip,
   output logic [15:0]      rsp_lease_seconds,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   logic [31:0] first_ip_ff, end_ip_ff;
   logic [15:0] offer_sec_ff, ack_sec_ff;
   logic                q_valid, q_ready, q_work;
   dhcp_pkg::cmd_type   q_cmd;
   dhcp_pkg::reply_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ip_ff  <= 32'd3232235876;
         end_ip_ff    <= 32'd3232235976;
         offer_sec_ff <= 16'd60;
         ack_sec_ff   <= 16'd900;
      end else if (csr_write) begin
         unique case (csr_index)
            dhcp_pkg::CSR_FIRST_IP:  first_ip_ff  <= csr_data;
            dhcp_pkg::CSR_END_IP:    end_ip_ff    <= csr_data;
            dhcp_pkg::CSR_OFFER_SEC: offer_sec_ff <= csr_data[15:0];
            dhcp_pkg::CSR_ACK_SEC:   ack_sec_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   dhcp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .xid_nonzero(req_xid_nonzero), .mac_given(req_mac_given),
      .client_mac(req_client_mac), .client_ip_given(req_client_ip_given),
      .client_ip(req_client_ip), .option_ip_given(req_option_ip_given),
      .option_ip(req_option_ip), .q_valid, .q_ready, .q_work, .q_cmd
   );

   dhcp_back #(.RECORD_COUNT(RECORD_COUNT)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_work, .q_cmd,
      .first_ip(first_ip_ff), .end_ip(end_ip_ff),
      .offer_sec(offer_sec_ff), .ack_sec(ack_sec_ff),
      .rsp_valid, .rsp_ready, .rsp_data(rsp)
   );

   assign rsp_reply_kind    = rsp.kind;
   assign rsp_your_ip       = rsp.ip;
   assign rsp_lease_seconds = rsp.lease;
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Lease table server bench: drives parsed client messages with random gaps,
// predicts every reply from a private copy of the lease table and checks the
// replies in order while the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class lease_scoreboard;
   localparam int NREC = 16;
   logic [1:0]  rec_status [NREC];
   logic [47:0] rec_mac    [NREC];
   logic [31:0] rec_ip     [NREC];
   logic [31:0] first_ip, end_ip;
   logic [15:0] offer_sec, ack_sec;
   dhcp_pkg::reply_type pending [$];
   int errors;

   function new();
      for (int i = 0; i < NREC; i++) begin
         rec_status[i] = dhcp_pkg::ST_FREE;
         rec_mac[i] = '0;
         rec_ip[i] = '0;
      end
      first_ip = 32'd3232235876;
      end_ip = 32'd3232235976;
      offer_sec = 16'd60;
      ack_sec = 16'd900;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
         dhcp_pkg::CSR_FIRST_IP: first_ip = val;
         dhcp_pkg::CSR_END_IP: end_ip = val;
         dhcp_pkg::CSR_OFFER_SEC: offer_sec = val[15:0];
         default: ack_sec = val[15:0];
      endcase
   endfunction

   function int find_ip(logic [31:0] ip);
      for (int i = 0; i < NREC; i++) if (rec_ip[i] == ip) return i;
      return -1;
   endfunction

   function dhcp_pkg::reply_type serve_discover(logic [47:0] mac);
      dhcp_pkg::reply_type r;
      int rec;
      logic [31:0] cand;
      bit found;
      r = '0;
      rec = -1;
      found = 0;
      for (int i = 0; i < NREC; i++) if (rec == -1 && rec_mac[i] == mac) rec = i;
      if (rec != -1 && rec_ip[rec] != 0) begin
         rec_status[rec] = dhcp_pkg::ST_OFFER;
         r.kind = dhcp_pkg::REPLY_OFFER;
         r.ip = rec_ip[rec];
         r.lease = offer_sec;
         return r;
      end
      if (rec == -1)
         for (int i = 0; i < NREC; i++)
            if (rec == -1 && rec_status[i] == dhcp_pkg::ST_FREE) rec = i;
      if (rec == -1) return r;
      cand = first_ip;
      for (int n = 0; n <= NREC && cand != end_ip; n++) begin
         if (find_ip(cand) == -1) begin
            found = 1;
            break;
         end
         cand = cand + 32'd1;
      end
      if (!found) return r;
      rec_ip[rec] = cand;
      rec_mac[rec] = mac;
      rec_status[rec] = dhcp_pkg::ST_OFFER;
      r.kind = dhcp_pkg::REPLY_OFFER;
      r.ip = cand;
      r.lease = offer_sec;
      return r;
   endfunction

   // note an accepted request and queue the reply it must produce
   function void note_request(logic [1:0] kind, logic xid, logic mg, logic [47:0] mac,
                              logic cg, logic [31:0] cip, logic og, logic [31:0] oip);
      dhcp_pkg::reply_type r;
      logic [31:0] addr;
      int rec;
      r = '0;
      rec = -1;
      if (xid && mg) begin
         if (kind == dhcp_pkg::MSG_DISCOVER) begin
            r = serve_discover(mac);
         end else if (kind == dhcp_pkg::MSG_REQUEST && (cg || og)) begin
            addr = cg ? cip : oip;
            for (int i = 0; i < NREC; i++)
               if (rec == -1 && rec_mac[i] == mac && rec_ip[i] == addr) rec = i;
            if (rec == -1 || rec_status[rec] == dhcp_pkg::ST_FREE) begin
               r.kind = dhcp_pkg::REPLY_NAK;
            end else begin
               rec_status[rec] = dhcp_pkg::ST_ASSIGNED;
               r.kind = dhcp_pkg::REPLY_ACK;
               r.ip = rec_ip[rec];
               r.lease = ack_sec;
            end
         end
      end
      pending.push_back(r);
   endfunction

   function void check_reply(logic [1:0] kind, logic [31:0] ip, logic [15:0] lease);
      dhcp_pkg::reply_type e;
      if (pending.size() == 0) begin
         $error("unexpected reply kind %0d", kind);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
         $error("reply_kind expected %0d actual %0d", e.kind, kind);
         errors++;
      end
      if (ip !== e.ip) begin
         $error("your_ip expected %h actual %h", e.ip, ip);
         errors++;
      end
      if (lease !== e.lease) begin
         $error("lease_seconds expected %0d actual %0d", e.lease, lease);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic        req_xid_nonzero = 0;
   logic        req_mac_given = 0;
   logic [47:0] req_client_mac = '0;
   logic        req_client_ip_given = 0;
   logic [31:0] req_client_ip = '0;
   logic        req_option_ip_given = 0;
   logic [31:0] req_option_ip = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_reply_kind;
   logic [31:0] rsp_your_ip;
   logic [15:0] rsp_lease_seconds;
   logic        csr_write = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   lease_scoreboard lease_sb = new();
   logic [47:0] mac_pool [8];
   bit          long_hold = 0;
   bit          ready_free = 0;

   dhcp_lease_table_server_top u_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         lease_sb.note_request(req_type, req_xid_nonzero, req_mac_given, req_client_mac,
                               req_client_ip_given, req_client_ip, req_option_ip_given,
                               req_option_ip);
      if (!reset && rsp_valid && rsp_ready)
         lease_sb.check_reply(rsp_reply_kind, rsp_your_ip, rsp_lease_seconds);
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int phase;
      phase = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         phase++;
         if (long_hold) rsp_ready <= 0;
         else if (ready_free) rsp_ready <= 1;
         else if ((phase / 64) % 3 == 0) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      lease_sb.write_reg(idx, val);
   endtask

   task automatic wait_drained();
      while (lease_sb.pending.size() != 0) @(negedge clock);
      repeat (16 * 17 + 40) @(negedge clock);
   endtask

   task automatic send(logic [1:0] kind, logic xid, logic mg, logic [47:0] mac,
                       logic cg, logic [31:0] cip, logic og, logic [31:0] oip);
      req_valid <= 1;
      req_type <= kind;
      req_xid_nonzero <= xid;
      req_mac_given <= mg;
      req_client_mac <= mac;
      req_client_ip_given <= cg;
      req_client_ip <= cip;
      req_option_ip_given <= og;
      req_option_ip <= oip;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // mostly well-formed traffic from a small client pool, some noise
   task automatic random_item();
      logic [47:0] mac;
      logic [31:0] ip;
      int pick;
      mac = ($urandom_range(0, 9) == 0) ? 48'({$urandom(), $urandom()})
                                        : mac_pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 2);
      ip = (pick == 0) ? lease_sb.first_ip + 32'($urandom_range(0, 20))
         : (pick == 1) ? 32'($urandom()) : lease_sb.rec_ip[$urandom_range(0, 15)];
      if ($urandom_range(0, 11) == 0)
         send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), mac, 1'($urandom_range(0, 1)), 32'($urandom()),
              1'($urandom_range(0, 1)), 32'($urandom()));
      else
         send($urandom_range(0, 2) == 0 ? dhcp_pkg::MSG_DISCOVER : dhcp_pkg::MSG_REQUEST,
              1, 1, mac, 1'($urandom_range(0, 1)), ip, 1'($urandom_range(0, 1)),
              ip ^ {31'd0, ($urandom_range(0, 3) == 0)});
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && count > 0) begin
            random_item();
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap();
      end
      req_valid <= 0;
   endtask

   initial begin
      int held;
      for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom(), $urandom()});
      mac_pool[7] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part
      ready_free = 1;
      send(dhcp_pkg::MSG_DISCOVER, 0, 1, mac_pool[0], 0, 0, 0, 0);
      send(dhcp_pkg::MSG_DISCOVER, 1, 0, mac_pool[0], 0, 0, 0, 0);
      send(dhcp_pkg::MSG_DISCOVER, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
      send(dhcp_pkg::MSG_REQUEST, 1, 1, 48'hFFFF_FFFF_FFFF, 1, 32'd3232235876, 0, 0);
      send(dhcp_pkg::MSG_REQUEST, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 1, 32'd3232235876);
      send(dhcp_pkg::MSG_REQUEST, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
      send(dhcp_pkg::MSG_REQUEST, 1, 1, 48'hFFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 1,
           32'hFFFF_FFFF);
      send(dhcp_pkg::MSG_DISCOVER, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
      send(dhcp_pkg::MSG_DISCOVER, 1, 1, 48'h0, 0, 0, 0, 0);
      send(dhcp_pkg::MSG_REQUEST, 1, 1, 48'h0, 0, 0, 1, 32'h0);
      send(dhcp_pkg::MSG_RELEASE, 1, 1, mac_pool[1], 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      send(dhcp_pkg::MSG_OTHER, 1, 1, mac_pool[1], 1, 0, 1, 0);
      for (int i = 0; i < 12; i++)
         send(dhcp_pkg::MSG_DISCOVER, 1, 1, 48'({$urandom(), $urandom()}), 0, 0, 0, 0);
      req_valid <= 0;
      wait_drained();

      // long receiver hold-off while requests keep coming
      ready_free = 0;
      fork
         begin
            long_hold = 1;
            held = 0;
            while (held < 300) begin
               @(negedge clock);
               held++;
            end
            long_hold = 0;
         end
         random_phase(30);
      join
      wait_drained();

      write_csr(dhcp_pkg::CSR_FIRST_IP, 32'hFFFF_FFFA);
      write_csr(dhcp_pkg::CSR_END_IP, 32'h0000_0004);
      write_csr(dhcp_pkg::CSR_OFFER_SEC, 32'h0000_FFFF);
      write_csr(dhcp_pkg::CSR_ACK_SEC, 32'h0);
      random_phase(250);
      wait_drained();

      write_csr(dhcp_pkg::CSR_FIRST_IP, 32'h0);
      write_csr(dhcp_pkg::CSR_END_IP, 32'h0000_0008);
      write_csr(dhcp_pkg::CSR_OFFER_SEC, 32'h0);
      write_csr(dhcp_pkg::CSR_ACK_SEC, 32'h0000_FFFF);
      random_phase(250);
      wait_drained();

      // empty range: first address equal to its end
      write_csr(dhcp_pkg::CSR_FIRST_IP, 32'h0A00_0005);
      write_csr(dhcp_pkg::CSR_END_IP, 32'h0A00_0005);
      random_phase(100);
      wait_drained();

      write_csr(dhcp_pkg::CSR_FIRST_IP, 32'($urandom()));
      write_csr(dhcp_pkg::CSR_END_IP, lease_sb.first_ip + 32'($urandom_range(1, 40)));
      write_csr(dhcp_pkg::CSR_OFFER_SEC, 32'($urandom()));
      write_csr(dhcp_pkg::CSR_ACK_SEC, 32'($urandom()));
      random_phase(400);
      wait_drained();

      if (lease_sb.errors == 0 && lease_sb.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
